/* sv/rrlh_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrlh_pkg
// Shared widths, register indexes, reset values and the command and status
// structures that join the controller and the datapath of the latency
// histogram block.
// ----------------------------------------------------------------------------
package rrlh_pkg;

    localparam int ADDR_W      = 32;
    localparam int TS_W        = 64;
    localparam int LAT_W       = 32;
    localparam int CNT_W       = 16;
    localparam int SUM_W       = 48;
    localparam int BIN_INDEX_W = 6;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 152;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_SOURCE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_DESTINATION  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_SOURCE      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESPONSE_DESTINATION = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_LIMIT         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BIN_WIDTH            = 3'd5;

    // Register reset values.
    localparam logic [ADDR_W-1:0] RST_REQUEST_SOURCE       = 32'hc0a8_001e;
    localparam logic [ADDR_W-1:0] RST_REQUEST_DESTINATION  = 32'hc0a8_00c8;
    localparam logic [ADDR_W-1:0] RST_RESPONSE_SOURCE      = 32'hc0a8_00c8;
    localparam logic [ADDR_W-1:0] RST_RESPONSE_DESTINATION = 32'hc0a8_000a;
    localparam logic [CNT_W-1:0]  RST_SAMPLE_LIMIT         = 16'd10000;
    localparam logic [CNT_W-1:0]  RST_BIN_WIDTH            = 16'd1000;

    // Result kinds carried on tuser.
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_BIN    = 1'b1;

    typedef struct packed {
        logic capture;      // latch the accepted request
        logic eval;         // phase decision and latency subtract
        logic update;       // totals update and divider load
        logic div_step;     // one quotient bit
        logic bin_rd;       // read the bin selected by the quotient
        logic bin_wr;       // write back the incremented bin
        logic load_sample;  // load a latency result into the output register
        logic dump_rd;      // read the bin selected by the dump counter
        logic load_dump;    // load a bin result into the output register
        logic dump_next;    // advance the dump counter
    } rrlh_cmd_t;

    typedef struct packed {
        logic sample;       // the captured request completes a pair
        logic div_last;     // final divider step
        logic halt_now;     // sample limit reached
        logic out_free;     // output register can take a result
        logic dump_last;    // dump counter at the last bin
    } rrlh_status_t;

endpackage
`default_nettype wire

/* sv/request_response_latency_histogram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// request_response_latency_histogram
// Measures request-to-response latency between two configured address pairs
// and keeps totals and a histogram, dumped once at the sample limit.
// ----------------------------------------------------------------------------
// The block takes one packet request at a time. A packet that does not
// complete a request/response pair is accepted and then evaluated. A matched
// response also passes through the totals update, the divider steps, a read
// and a write of the single-port histogram memory and the output load: the bin
// index comes from a divider that produces one quotient bit per cycle. When the
// sample limit is reached, the latency result is followed by one result per bin,
// each as a memory read, then output, after which the block takes and drops
// every request until reset. The histogram is cleared at reset by per-bin valid
// flags, so no clearing pass is needed. Results pass through one output
// register; the block keeps accepting while a result waits there.
// ----------------------------------------------------------------------------
module request_response_latency_histogram #(
    parameter int NUM_BINS = 60
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rrlh_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rrlh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // source_address, dest_address, timestamp_us
    input  wire logic [rrlh_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // latency, sample_count, latency_sum, latency_max, bin_index, bin_value
    output logic [rrlh_pkg::OUT_TDATA_W-1:0]       m_tdata,
    // kind
    output logic                                   m_tuser,
    output logic                                   m_tlast
);
    import rrlh_pkg::*;

    rrlh_cmd_t    cmd;
    rrlh_status_t status;

    rrlh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rrlh_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

/* sv/rrlh_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrlh_ctrl
// Sequencer for the latency histogram: takes one request at a time, steps the
// datapath through evaluation, update, division and bin update, then issues
// the result and, at the sample limit, the bin dump before halting.
// ----------------------------------------------------------------------------
module rrlh_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire rrlh_pkg::rrlh_status_t status,
    output rrlh_pkg::rrlh_cmd_t        cmd
);
    import rrlh_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_EVAL  = 10'b00_0000_0010,
        ST_UPD   = 10'b00_0000_0100,
        ST_DIV   = 10'b00_0000_1000,
        ST_RD    = 10'b00_0001_0000,
        ST_WR    = 10'b00_0010_0000,
        ST_EMIT  = 10'b00_0100_0000,
        ST_DRD   = 10'b00_1000_0000,
        ST_DOUT  = 10'b01_0000_0000,
        ST_HALT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.sample ? ST_UPD : ST_IDLE;
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.bin_rd = 1'b1;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                cmd.bin_wr = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = status.halt_now ? ST_DRD : ST_IDLE;
                end
            end
            ST_DRD:
            begin
                cmd.dump_rd = 1'b1;
                state_next  = ST_DOUT;
            end
            ST_DOUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_dump = 1'b1;
                    if (status.dump_last)
                    begin
                        state_next = ST_HALT;
                    end
                    else
                    begin
                        cmd.dump_next = 1'b1;
                        state_next    = ST_DRD;
                    end
                end
            end
            ST_HALT:
            begin
                // Requests are still taken, but dropped until reset.
                s_tready   = 1'b1;
                state_next = ST_HALT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* sv/rrlh_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrlh_datapath
// Configuration registers, pair matching, latency totals, a bit-per-cycle
// bin divider, the histogram memory and the output register.
// ----------------------------------------------------------------------------
module rrlh_datapath #(
    parameter int NUM_BINS = 60
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [rrlh_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [rrlh_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [rrlh_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  wire rrlh_pkg::rrlh_cmd_t                 cmd,
    output rrlh_pkg::rrlh_status_t                   status,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [rrlh_pkg::OUT_TDATA_W-1:0]         m_tdata,
    output logic                                     m_tuser,
    output logic                                     m_tlast
);
    import rrlh_pkg::*;

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int DW = AW + CNT_W;
    localparam int CW = (AW > 1) ? $clog2(AW) : 1;
    localparam int PAD_W = OUT_TDATA_W - (LAT_W + CNT_W + SUM_W + LAT_W
                                          + BIN_INDEX_W + CNT_W);

    // Configuration.
    logic [ADDR_W-1:0] req_src_reg;
    logic [ADDR_W-1:0] req_dst_reg;
    logic [ADDR_W-1:0] rsp_src_reg;
    logic [ADDR_W-1:0] rsp_dst_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  width_reg;

    // Captured request.
    logic [ADDR_W-1:0] src_reg;
    logic [ADDR_W-1:0] dst_reg;
    logic [LAT_W-1:0]  ts_reg;

    // Running state.
    logic              phase_reg;
    logic [LAT_W-1:0]  req_time_reg;
    logic [LAT_W-1:0]  lat_reg;
    logic [CNT_W-1:0]  samples_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [LAT_W-1:0]  max_reg;

    // Divider.
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dvs_reg;
    logic [AW-1:0]     quot_reg;
    logic [CW-1:0]     cnt_reg;
    logic              in_range_reg;

    // Histogram.
    logic [CNT_W-1:0]    mem [NUM_BINS];
    logic [NUM_BINS-1:0] bin_valid_reg;
    logic [CNT_W-1:0]    rd_data_reg;
    logic                rd_valid_reg;
    logic [AW-1:0]       idx_reg;

    // Output register.
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_kind_reg;
    logic                   out_last_reg;

    logic                   req_match;
    logic                   rsp_match;
    logic [CNT_W-1:0]       width_eff;
    logic [DW-1:0]          range_limit;
    logic [SUM_W:0]         sum_ext;
    logic                   div_ge;
    logic [AW-1:0]          rd_addr;
    logic [CNT_W-1:0]       bin_cur;
    logic [CNT_W-1:0]       bin_inc;
    logic                   out_free;
    logic [CNT_W-1:0]       res_bin_value;
    logic [BIN_INDEX_W-1:0] res_bin_index;

    assign req_match   = (src_reg == req_src_reg) && (dst_reg == req_dst_reg);
    assign rsp_match   = (src_reg == rsp_src_reg) && (dst_reg == rsp_dst_reg);
    assign width_eff   = (width_reg == '0) ? CNT_W'(1) : width_reg;
    assign range_limit = DW'(NUM_BINS) * DW'(width_eff);
    assign sum_ext     = {1'b0, sum_reg} + (SUM_W + 1)'(lat_reg);
    assign div_ge      = (rem_reg >= dvs_reg);
    assign rd_addr     = cmd.dump_rd ? idx_reg : quot_reg;
    assign bin_cur     = rd_valid_reg ? rd_data_reg : '0;
    assign bin_inc     = (bin_cur == {CNT_W{1'b1}}) ? bin_cur : bin_cur + CNT_W'(1);
    assign out_free    = !out_valid_reg || m_tready;

    assign res_bin_value = rd_valid_reg ? rd_data_reg : '0;
    assign res_bin_index = BIN_INDEX_W'(idx_reg);

    assign status.sample    = phase_reg && rsp_match;
    assign status.div_last  = (cnt_reg == '0);
    assign status.halt_now  = !(samples_reg < limit_reg);
    assign status.out_free  = out_free;
    assign status.dump_last = (idx_reg == AW'(NUM_BINS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_src_reg <= RST_REQUEST_SOURCE;
            req_dst_reg <= RST_REQUEST_DESTINATION;
            rsp_src_reg <= RST_RESPONSE_SOURCE;
            rsp_dst_reg <= RST_RESPONSE_DESTINATION;
            limit_reg   <= RST_SAMPLE_LIMIT;
            width_reg   <= RST_BIN_WIDTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REQUEST_SOURCE:       req_src_reg <= cfg_data;
                REG_REQUEST_DESTINATION:  req_dst_reg <= cfg_data;
                REG_RESPONSE_SOURCE:      rsp_src_reg <= cfg_data;
                REG_RESPONSE_DESTINATION: rsp_dst_reg <= cfg_data;
                REG_SAMPLE_LIMIT:         limit_reg   <= cfg_data[CNT_W-1:0];
                REG_BIN_WIDTH:            width_reg   <= cfg_data[CNT_W-1:0];
                default:                  ;
            endcase
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            src_reg <= s_tdata[ADDR_W-1:0];
            dst_reg <= s_tdata[2*ADDR_W-1:ADDR_W];
            ts_reg  <= s_tdata[2*ADDR_W+LAT_W-1:2*ADDR_W];
        end
        if (cmd.eval && !phase_reg && req_match)
        begin
            req_time_reg <= ts_reg;
        end
        if (cmd.eval)
        begin
            // Only the low word of the timestamps matters modulo 2^32.
            lat_reg <= ts_reg - req_time_reg;
        end
        if (cmd.update)
        begin
            rem_reg      <= lat_reg[DW-1:0];
            dvs_reg      <= DW'(width_eff) << (AW - 1);
            quot_reg     <= '0;
            in_range_reg <= (lat_reg < LAT_W'(range_limit));
        end
        else if (cmd.div_step)
        begin
            if (div_ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg  <= dvs_reg >> 1;
            quot_reg <= AW'({quot_reg, div_ge});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= 1'b0;
            samples_reg <= '0;
            sum_reg     <= '0;
            max_reg     <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cmd.eval)
            begin
                phase_reg <= !phase_reg && req_match;
            end
            if (cmd.update)
            begin
                if (samples_reg != {CNT_W{1'b1}})
                begin
                    samples_reg <= samples_reg + CNT_W'(1);
                end
                sum_reg <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
                if (lat_reg > max_reg)
                begin
                    max_reg <= lat_reg;
                end
                cnt_reg <= CW'(AW - 1);
            end
            else if (cmd.div_step && cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.dump_next)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
        end
    end

    // Histogram memory; an entry never written since reset reads as zero.
    always_ff @(posedge clk)
    begin
        if (cmd.bin_wr && in_range_reg)
        begin
            mem[quot_reg] <= bin_inc;
        end
        if (cmd.bin_rd || cmd.dump_rd)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= bin_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
        end
        else if (cmd.bin_wr && in_range_reg)
        begin
            bin_valid_reg[quot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_sample || cmd.load_dump)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, {CNT_W{1'b0}}, {BIN_INDEX_W{1'b0}},
                             max_reg, sum_reg, samples_reg, lat_reg};
            out_kind_reg <= KIND_SAMPLE;
            out_last_reg <= !status.halt_now;
        end
        else if (cmd.load_dump)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, res_bin_value, res_bin_index,
                             max_reg, sum_reg, samples_reg, lat_reg};
            out_kind_reg <= KIND_BIN;
            out_last_reg <= status.dump_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire
